>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the handle pool allocator.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while the reset is released.
`define HPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, including those during reset.
`define HPA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hdl/hpa_pkg.sv
// Shared types and codes of the handle pool allocator.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package hpa_pkg;

    // Field widths of the two channels.
    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Command codes of an input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_TRY   = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Status codes of a result transaction.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

>>> hdl/hpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the release queue of the allocator.
`timescale 1ns / 1ps
`default_nettype none

module hpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/hpa_ctrl.sv
// Controller of the handle pool allocator: handshakes and sequencing.
// Depends on hpa_pkg for the datapath command struct.
`timescale 1ns / 1ps
`default_nettype none

module hpa_ctrl
    import hpa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;

    // A new transaction is taken when idle, or when the waiting result
    // leaves in the same cycle.
    assign o_in_ready  = (r_state == S_IDLE) || ((r_state == S_DONE) && i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == S_EXEC);

    // State and the registered result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_DONE;
                    r_out_valid <= 1'b1;
                end
                S_DONE: begin
                    if (w_accept) begin
                        r_state     <= S_EXEC;
                        r_out_valid <= 1'b0;
                    end else if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/hpa_datapath.sv
// Datapath of the handle pool allocator: release queue, in-use bitmap,
// counters and the result register. Depends on hpa_pkg and hpa_ram.
`timescale 1ns / 1ps
`default_nettype none

module hpa_datapath
    import hpa_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [HANDLE_W-1:0] i_handle_in,
    output logic      [HANDLE_W-1:0] o_handle_out,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [COUNT_W-1:0]  o_allocated_count,
    output logic      [COUNT_W-1:0]  o_released_count
);

    // Only handles below 256 can ever be released, so the queue and the
    // bitmap need no more entries than that.
    localparam int FD = (POOL_SIZE < 256) ? POOL_SIZE : 256;
    localparam int HW = $clog2(FD);
    localparam int CW = $clog2(FD + 1);
    localparam int NW = $clog2(POOL_SIZE + 1);
    localparam int HN = $clog2(POOL_SIZE);
    localparam logic [12:0] POOL_LIMIT = 13'(POOL_SIZE);

    // Transaction held for execution.
    t_cmd                r_cmd;
    logic [HANDLE_W-1:0] r_hin;

    // Queue pointers, counters and bitmap.
    logic [HW-1:0] r_head, n_head;
    logic [HW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_fcount, n_fcount;
    logic [NW-1:0] r_created, n_created;
    logic [NW-1:0] r_used, n_used;
    logic [FD-1:0] r_map, n_map;

    logic [HW-1:0] w_rdata;
    logic          w_push;
    logic [HN-1:0] w_hout;
    t_status       w_status;
    logic          w_hin_ok;

    logic [HN+HANDLE_W-1:0] w_hout_ext;
    logic [NW+COUNT_W-1:0]  w_used_ext;
    logic [CW+COUNT_W-1:0]  w_fcount_ext;

    // Release queue storage; the head entry is read every cycle.
    hpa_ram #(
        .WIDTH (HW),
        .DEPTH (FD)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && w_push),
        .i_waddr (r_tail),
        .i_wdata (r_hin[HW-1:0]),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // Capture of an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= t_cmd'(i_command);
            r_hin <= i_handle_in;
        end
    end

    assign w_hin_ok = ({5'b0, r_hin} < POOL_LIMIT);

    // Execution of the held command.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fcount  = r_fcount;
        n_created = r_created;
        n_used    = r_used;
        n_map     = r_map;
        w_push    = 1'b0;
        w_hout    = '0;
        w_status  = ST_OK;
        case (r_cmd)
            CMD_ALLOC, CMD_TRY: begin
                if (r_fcount != '0) begin
                    // Reuse the oldest released handle.
                    w_hout         = HN'(w_rdata);
                    n_map[w_rdata] = 1'b1;
                    n_head         = (r_head == HW'(FD - 1)) ? '0 : r_head + 1'b1;
                    n_fcount       = r_fcount - 1'b1;
                    n_used         = r_used + 1'b1;
                end else if (r_cmd == CMD_TRY) begin
                    w_status = ST_EMPTY;
                end else if (r_created < NW'(POOL_SIZE)) begin
                    // Create a fresh handle.
                    w_hout = HN'(r_created);
                    if (r_created < NW'(FD)) begin
                        n_map[r_created[HW-1:0]] = 1'b1;
                    end
                    n_created = r_created + 1'b1;
                    n_used    = r_used + 1'b1;
                end else begin
                    w_status = ST_EXHAUSTED;
                end
            end
            CMD_FREE: begin
                if (!w_hin_ok || !r_map[r_hin[HW-1:0]]) begin
                    w_status = ST_NOT_ALLOC;
                end else begin
                    n_map[r_hin[HW-1:0]] = 1'b0;
                    n_used               = r_used - 1'b1;
                    if (r_fcount < CW'(FD)) begin
                        w_push   = 1'b1;
                        n_tail   = (r_tail == HW'(FD - 1)) ? '0 : r_tail + 1'b1;
                        n_fcount = r_fcount + 1'b1;
                    end
                end
            end
            CMD_NONE: begin
                w_status = ST_OK;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // State update on execution.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_fcount  <= '0;
            r_created <= '0;
            r_used    <= '0;
            r_map     <= '0;
        end else if (i_cmd.exec) begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fcount  <= n_fcount;
            r_created <= n_created;
            r_used    <= n_used;
            r_map     <= n_map;
        end
    end

    // Results are reduced to the field widths.
    assign w_hout_ext   = (HN + HANDLE_W)'(w_hout);
    assign w_used_ext   = (NW + COUNT_W)'(n_used);
    assign w_fcount_ext = (CW + COUNT_W)'(n_fcount);

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_handle_out      <= w_hout_ext[HANDLE_W-1:0];
            o_status          <= w_status;
            o_allocated_count <= w_used_ext[COUNT_W-1:0];
            o_released_count  <= w_fcount_ext[COUNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hdl/fifo_handle_pool_allocator.sv
// Handle pool allocator: hands out handles 0 .. POOL_SIZE-1.
// Input channel (i_in_valid / o_in_ready) carries i_command and i_handle_in:
// allocate reuses the oldest released handle or creates a new one, try
// allocate only reuses, deallocate checks the handle and queues it.
// Output channel (o_out_valid / i_out_ready) carries one result per command:
// o_handle_out, o_status and the allocated and released counts.
// A command is captured at the rising edge that accepts it; the EXEC state
// then executes it and loads the result register, which raises o_out_valid.
// The input is not ready during the execution step, so a new command is not
// taken before the previous one has executed.
// A result waits in its output register while the receiver stalls; the
// next command is taken in the cycle the waiting result leaves.
// Reset (i_rst_n low, synchronous) empties the release queue, clears the
// in-use bitmap and counters and drops any result in flight. No clearing
// pass is needed, so commands are accepted as soon as reset is released.
// Depends on hpa_pkg, hpa_ctrl, hpa_datapath and hpa_ram.
`timescale 1ns / 1ps
`default_nettype none

module fifo_handle_pool_allocator
    import hpa_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [HANDLE_W-1:0] i_handle_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [HANDLE_W-1:0] o_handle_out,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [COUNT_W-1:0]  o_allocated_count,
    output logic      [COUNT_W-1:0]  o_released_count
);

    t_dp_cmd w_cmd;

    // Sequencing and handshakes.
    hpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Queue, bitmap, counters and result register.
    hpa_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_command         (i_command),
        .i_handle_in       (i_handle_in),
        .o_handle_out      (o_handle_out),
        .o_status          (o_status),
        .o_allocated_count (o_allocated_count),
        .o_released_count  (o_released_count)
    );

endmodule

`default_nettype wire

>>> hdl/hpa_checker.sv
// Port-level assertions of the handle pool allocator and their binding.
// Depends on hpa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hpa_checker
    import hpa_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [HANDLE_W-1:0] o_handle_out,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [COUNT_W-1:0]  o_released_count
);

    logic w_out_stall;
    logic w_in_accept;
    logic w_failed;
    logic w_no_reuse;

    // Conditions observed on the ports.
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_failed    = o_out_valid && (o_status != ST_OK);
    assign w_no_reuse  = o_out_valid && (o_status == ST_EMPTY || o_status == ST_EXHAUSTED);

    // A stalled result stays offered.
    `HPA_ASSERT(a_out_hold, w_out_stall |=> o_out_valid, "result dropped while stalled")

    // Reset removes any pending result.
    `HPA_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // Every accepted transaction yields its result after the execution step.
    `HPA_ASSERT(a_latency, w_in_accept |=> !o_out_valid ##1 o_out_valid, "result latency wrong")

    // A failed command grants no handle.
    `HPA_ASSERT(a_fail_zero, w_failed |-> o_handle_out == '0, "handle on failure")

    // Empty or exhausted reports only with nothing in the release queue.
    `HPA_ASSERT(a_empty_queue, w_no_reuse |-> o_released_count == '0, "queue not empty")

endmodule

bind fifo_handle_pool_allocator hpa_checker u_hpa_checker (.*);

`default_nettype wire

>>> test/tb_fifo_handle_pool_allocator.sv
// Self-checking testbench of the handle pool allocator.
// Depends on hpa_pkg and fifo_handle_pool_allocator; a behavioural pool model
// predicts every result, which a monitor compares field by field.
`timescale 1ns / 1ps

module tb_fifo_handle_pool_allocator;
    import hpa_pkg::*;

    localparam int POOL_SIZE   = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 32;
    localparam int SHOW_LIMIT  = 10;

    // One result transaction as the pool model predicts it.
    typedef struct {
        logic [HANDLE_W-1:0] handle;
        t_status             status;
        logic [COUNT_W-1:0]  alloc_cnt;
        logic [COUNT_W-1:0]  rel_cnt;
    } t_pool_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [CMD_W-1:0]    i_command   = CMD_NONE;
    logic [HANDLE_W-1:0] i_handle_in = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_allocated_count;
    logic [COUNT_W-1:0]  o_released_count;

    // Model state of the pool.
    logic [HANDLE_W-1:0] released_handles[$];
    bit                  handle_busy[POOL_SIZE];
    int                  handles_made = 0;
    int                  handles_out  = 0;

    // Results awaited from the block, oldest first.
    t_pool_result        awaited_results[$];

    // Run statistics and failure counters.
    bit                  stall_on = 1'b1;
    int                  cycle_count = 0;
    int                  mismatch_count = 0;
    int                  unexpected_count = 0;
    int                  results_checked = 0;
    int                  cmd_sent[4];
    int                  status_seen[4];
    int                  peak_released = 0;

    fifo_handle_pool_allocator #(
        .POOL_SIZE(POOL_SIZE)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_handle_in       (i_handle_in),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_handle_out      (o_handle_out),
        .o_status          (o_status),
        .o_allocated_count (o_allocated_count),
        .o_released_count  (o_released_count)
    );

    // Clock with a 20 ns period.
    always #10 i_clk = ~i_clk;

    // Receiver back-pressure: ready drops at random while stalling is enabled.
    always @(posedge i_clk) begin
        i_out_ready <= stall_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Watchdog on the length of the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, awaited_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Applies one command to the pool model and returns the result it gives.
    function automatic t_pool_result model_command(t_cmd cmd, logic [HANDLE_W-1:0] hin);
        t_pool_result r;
        r.handle = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_ALLOC, CMD_TRY: begin
                if (released_handles.size() > 0) begin
                    r.handle = released_handles.pop_front();
                    handle_busy[r.handle] = 1'b1;
                    handles_out++;
                end else if (cmd == CMD_TRY) begin
                    r.status = ST_EMPTY;
                end else if (handles_made < POOL_SIZE) begin
                    r.handle = HANDLE_W'(handles_made);
                    handles_made++;
                    handle_busy[r.handle] = 1'b1;
                    handles_out++;
                end else begin
                    r.status = ST_EXHAUSTED;
                end
            end
            CMD_FREE: begin
                if (!handle_busy[hin]) begin
                    r.status = ST_NOT_ALLOC;
                end else begin
                    handle_busy[hin] = 1'b0;
                    handles_out--;
                    released_handles.push_back(hin);
                end
            end
            default: begin
                // The unused command leaves the pool untouched.
            end
        endcase
        r.alloc_cnt = COUNT_W'(handles_out);
        r.rel_cnt   = COUNT_W'(released_handles.size());
        return r;
    endfunction

    // Sends one command transaction, idling beforehand at random, and
    // records the predicted result once the block has taken it.
    task automatic send_command(t_cmd cmd, logic [HANDLE_W-1:0] hin);
        t_pool_result r;
        while (stall_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_handle_in <= hin;
        do @(posedge i_clk); while (!o_in_ready);
        r = model_command(cmd, hin);
        awaited_results.push_back(r);
        cmd_sent[cmd]++;
        status_seen[r.status]++;
        if (released_handles.size() > peak_released)
            peak_released = released_handles.size();
    endtask

    // Chooses a handle to release: mostly one that is allocated, otherwise any.
    function automatic logic [HANDLE_W-1:0] pick_release_handle(int bad_pct);
        int n;
        int k;
        n = 0;
        foreach (handle_busy[i]) if (handle_busy[i]) n++;
        if (n == 0 || $urandom_range(0, 99) < bad_pct)
            return HANDLE_W'($urandom_range(0, 255));
        k = $urandom_range(0, n - 1);
        foreach (handle_busy[i]) begin
            if (handle_busy[i]) begin
                if (k == 0) return HANDLE_W'(i);
                k--;
            end
        end
        return '0;
    endfunction

    // Monitor: compares each accepted result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_pool_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                unexpected_count++;
                if (unexpected_count + mismatch_count <= SHOW_LIMIT)
                    $display("Unexpected result: handle %0d status %0d alloc %0d rel %0d",
                             o_handle_out, o_status, o_allocated_count, o_released_count);
            end else begin
                e = awaited_results.pop_front();
                results_checked++;
                if (o_handle_out !== e.handle || o_status !== e.status ||
                    o_allocated_count !== e.alloc_cnt || o_released_count !== e.rel_cnt) begin
                    mismatch_count++;
                    if (unexpected_count + mismatch_count <= SHOW_LIMIT) begin
                        $display("Mismatch on result %0d: expected handle %0d status %0d %s",
                                 results_checked, e.handle, e.status, "");
                        $display("  expected alloc %0d rel %0d, got handle %0d status %0d",
                                 e.alloc_cnt, e.rel_cnt, o_handle_out, o_status);
                        $display("  got alloc %0d rel %0d",
                                 o_allocated_count, o_released_count);
                    end
                end
            end
        end
    end

    // Directed: empty pool, bad releases, fresh growth, FIFO order of reuse
    // and the unused command.
    task automatic test_basic_sequence();
        send_command(CMD_TRY, 8'h00);
        send_command(CMD_FREE, 8'h00);
        send_command(CMD_FREE, 8'hFF);
        send_command(CMD_ALLOC, 8'hFF);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_ALLOC, 8'hAA);
        send_command(CMD_FREE, 8'h01);
        send_command(CMD_FREE, 8'h01);
        send_command(CMD_TRY, 8'h55);
        send_command(CMD_NONE, 8'hFF);
        send_command(CMD_FREE, 8'h00);
        send_command(CMD_FREE, 8'h02);
        send_command(CMD_NONE, 8'h00);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_TRY, 8'h00);
        send_command(CMD_ALLOC, 8'h00);
        send_command(CMD_TRY, 8'h00);
        send_command(CMD_FREE, 8'h80);
        send_command(CMD_FREE, 8'h7F);
    endtask

    // Grows the pool until every handle exists, then runs into exhaustion
    // and checks that released handles are still reused afterwards.
    task automatic test_fill_to_exhaustion();
        int r;
        while (handles_made < POOL_SIZE) begin
            r = $urandom_range(0, 99);
            if (r < 85)
                send_command(CMD_ALLOC, HANDLE_W'($urandom_range(0, 255)));
            else if (r < 93)
                send_command(CMD_FREE, pick_release_handle(10));
            else
                send_command(CMD_TRY, HANDLE_W'($urandom_range(0, 255)));
        end
        while (released_handles.size() > 0)
            send_command(CMD_ALLOC, '0);
        repeat (3) send_command(CMD_ALLOC, HANDLE_W'($urandom_range(0, 255)));
        send_command(CMD_TRY, '0);
        repeat (2) send_command(CMD_FREE, pick_release_handle(0));
        repeat (3) send_command(CMD_ALLOC, '0);
    endtask

    // Releases every allocated handle in random order, with some bad
    // releases in between, so that the release FIFO fills completely.
    task automatic test_release_all();
        logic [HANDLE_W-1:0] order[$];
        logic [HANDLE_W-1:0] tmp;
        int j;
        foreach (handle_busy[i]) if (handle_busy[i]) order.push_back(HANDLE_W'(i));
        for (int i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i]) begin
            if ($urandom_range(0, 99) < 8)
                send_command(CMD_FREE, HANDLE_W'($urandom_range(0, 255)));
            send_command(CMD_FREE, order[i]);
        end
        send_command(CMD_FREE, order.size() > 0 ? order[0] : 8'h00);
    endtask

    // Random mix of all commands on a partly used pool.
    task automatic test_random_mix(int n_items);
        int r;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send_command(CMD_ALLOC, HANDLE_W'($urandom_range(0, 255)));
            else if (r < 55)
                send_command(CMD_TRY, HANDLE_W'($urandom_range(0, 255)));
            else if (r < 90)
                send_command(CMD_FREE, pick_release_handle(20));
            else
                send_command(CMD_NONE, HANDLE_W'($urandom_range(0, 255)));
        end
    endtask

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_sequence();
        test_fill_to_exhaustion();
        stall_on = 1'b0;
        test_release_all();
        stall_on = 1'b1;
        test_random_mix(220);
        i_in_valid <= 1'b0;

        // Drain the outstanding results and let the bench idle before the report.
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d allocate, %0d try, %0d release and %0d unused commands.",
                 cmd_sent[CMD_ALLOC], cmd_sent[CMD_TRY], cmd_sent[CMD_FREE],
                 cmd_sent[CMD_NONE]);
        $display("Checked %0d results, ok/empty/bad/exhausted %0d/%0d/%0d/%0d, peak queue %0d.",
                 results_checked, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_NOT_ALLOC], status_seen[ST_EXHAUSTED], peak_released);
        $display("%0d mismatches in total.", mismatch_count + unexpected_count);
        if (mismatch_count == 0 && unexpected_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
